// File: hdl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants and types for the 3x3 box mean filter stream block.
// ----------------------------------------------------------------------------
package bf3_pkg;

  // Frame geometry and pixel format
  localparam int MAX_WIDTH  = 1024;
  localparam int PIX_BITS   = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = 16;
  localparam int CFG_W_BITS = 11;
  localparam int PEND_BITS  = 11;
  localparam logic [PEND_BITS-1:0] PEND_MAX = '1;

  // Window and arithmetic
  localparam int WIN_COLS   = 3;
  localparam int CSUM_BITS  = 10;
  localparam int TOTAL_BITS = 12;
  localparam logic [TOTAL_BITS-1:0] ROUND_BIAS = 12'd4;
  // (x * RECIP_9) >> RECIP_SHIFT equals x / 9 for every x below 4096 / 1.7
  localparam logic [TOTAL_BITS-1:0] RECIP_9 = 12'd3641;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_BITS   = 2 * TOTAL_BITS;

  // Output queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [COL_BITS-1:0] col_idx_t;
  typedef logic [ROW_BITS-1:0] row_idx_t;

  // One window column: top (oldest line), middle, bottom (newest pixel)
  typedef struct packed {
    pix_t                 older;
    pix_t                 newer;
    pix_t                 pix;
    logic [CSUM_BITS-1:0] sum;
  } column_t;

  // Position and classification of an emitted pixel
  typedef struct packed {
    row_idx_t row;
    col_idx_t col;
    logic     frame_end;
    logic     interior;
  } meta_t;

  typedef struct packed {
    pix_t     pixel_out;
    row_idx_t out_row;
    col_idx_t out_col;
    logic     frame_end;
  } result_t;

endpackage

// File: hdl/bf3_if.sv
// ----------------------------------------------------------------------------
// bf3_if
// Valid/ready channels for incoming pixel beats and outgoing result beats.
// ----------------------------------------------------------------------------
interface bf3_pix_if;
  import bf3_pkg::*;

  logic valid;
  logic ready;
  logic op;
  pix_t pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface bf3_res_if;
  import bf3_pkg::*;

  logic     valid;
  logic     ready;
  pix_t     pixel_out;
  row_idx_t out_row;
  col_idx_t out_col;
  logic     frame_end;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

// File: hdl/bf3_cell.sv
// ----------------------------------------------------------------------------
// bf3_cell
// One window column cell: holds three pixels and their sum, hands them on.
// ----------------------------------------------------------------------------
module bf3_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  bf3_pkg::column_t col_in,
  output bf3_pkg::column_t col_q
);
  import bf3_pkg::*;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

endmodule

// File: hdl/bf3_line_store.sv
// ----------------------------------------------------------------------------
// bf3_line_store
// Two line memories with one registered read port and one write port each,
// cleared by a sweep of one entry per cycle after reset.
// ----------------------------------------------------------------------------
module bf3_line_store (
  input  logic              clk,
  input  logic              rst,
  input  bf3_pkg::col_idx_t rd_addr,
  output bf3_pkg::pix_t     rd_older,
  output bf3_pkg::pix_t     rd_newer,
  input  logic              wr_en,
  input  bf3_pkg::col_idx_t wr_addr,
  input  bf3_pkg::pix_t     wr_older,
  input  bf3_pkg::pix_t     wr_newer,
  output logic              busy
);
  import bf3_pkg::*;

  pix_t     older_mem [MAX_WIDTH];
  pix_t     newer_mem [MAX_WIDTH];
  col_idx_t clr_addr;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == col_idx_t'(MAX_WIDTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write clear data or line data; read old contents
  always_ff @(posedge clk) begin
    if (busy) begin
      older_mem[clr_addr] <= '0;
      newer_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
    rd_older <= older_mem[rd_addr];
    rd_newer <= newer_mem[rd_addr];
  end

endmodule

// File: hdl/box_filter_3x3_stream.sv
// Datapath: the edge that accepts the input beat releasing a result beat also starts the line read;
//   the beat then passes the window shift, the sum and the divide into the queue.
// Throughput: one input beat per cycle while the output queue and stages hold under OQ_DEPTH beats,
//   set by the separate line read and write ports and the one-column-per-pixel-beat shift of the cell chain.
// Reset: control clears at once; the line stores then run a clearing pass over every entry,
//   during which no input beat is taken (config writes are).
// ----------------------------------------------------------------------------
// box_filter_3x3_stream
// 3x3 box mean filter over a raster pixel stream with border passthrough.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream (
  input  logic                              clk,
  input  logic                              rst,
  bf3_pix_if.sink                           pixels,
  bf3_res_if.source                         results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bf3_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bf3_pkg::*;

  typedef struct packed {
    row_idx_t row;
    col_idx_t col;
  } pos_t;

  // Step a raster position against the frame size
  function automatic pos_t next_pos(pos_t p, logic [CFG_W_BITS-1:0] w,
                                    logic [ROW_BITS-1:0] h);
    logic [COL_BITS:0] col_inc;
    logic [ROW_BITS:0] row_inc;
    pos_t              n;
    col_inc = {1'b0, p.col} + 1'b1;
    row_inc = {1'b0, p.row} + 1'b1;
    n       = p;
    if (col_inc >= w) begin
      n.col = '0;
      n.row = (row_inc >= {1'b0, h}) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      n.col = col_inc[COL_BITS-1:0];
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W_BITS-1:0] frame_width;
  logic [ROW_BITS-1:0]   frame_height;
  logic                  reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W_BITS'(MAX_WIDTH);
      frame_height <= ROW_BITS'(1024);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {{(32-CFG_W_BITS){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(32-ROW_BITS){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  // Clamp the frame size: zero to one, and the width to what the line stores hold
  logic [CFG_W_BITS-1:0] w_eff;
  logic [ROW_BITS-1:0]   h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CFG_W_BITS'(1);
    end else if (frame_width > CFG_W_BITS'(MAX_WIDTH)) begin
      w_eff = CFG_W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height == '0) ? ROW_BITS'(1) : frame_height;
  end

  // --------------------------------------------------------------------------
  // Accept stage: counters and emission decision
  // --------------------------------------------------------------------------
  pos_t                 in_pos;
  pos_t                 emit_pos;
  logic [PEND_BITS-1:0] pending;
  logic [PEND_BITS-1:0] pend_inc;
  logic                 acc;
  logic                 is_drain;
  logic                 pix_emit;
  logic                 drn_emit;
  logic                 emit;
  logic                 sel_older;
  meta_t                emit_meta;
  col_idx_t             rd_addr;
  logic                 ls_busy;
  logic [OQ_AW:0]       oq_count;
  logic [OQ_AW+1:0]     in_flight;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 s3_valid;

  assign in_flight = {1'b0, oq_count} + (OQ_AW+2)'(s1_valid) + (OQ_AW+2)'(s2_valid)
                   + (OQ_AW+2)'(s3_valid);
  assign pixels.ready = !ls_busy && (in_flight < (OQ_AW+2)'(OQ_DEPTH));
  assign acc      = pixels.valid && pixels.ready;
  assign is_drain = (pixels.op == OP_DRAIN);

  always_comb begin
    pend_inc  = (pending != PEND_MAX) ? pending + 1'b1 : pending;
    pix_emit  = {1'b0, pend_inc} >= ({1'b0, w_eff} + (CFG_W_BITS+1)'(2));
    drn_emit  = (pending != '0);
    emit      = is_drain ? drn_emit : pix_emit;
    sel_older = (pending > w_eff);
    rd_addr   = is_drain ? emit_pos.col : in_pos.col;

    emit_meta.row       = emit_pos.row;
    emit_meta.col       = emit_pos.col;
    emit_meta.frame_end = (({1'b0, emit_pos.row} + 1'b1) >= {1'b0, h_eff}) &&
                          (({1'b0, emit_pos.col} + 1'b1) >= w_eff);
    emit_meta.interior  = (emit_pos.row != '0) &&
                          (({1'b0, emit_pos.row} + 1'b1) < {1'b0, h_eff}) &&
                          (emit_pos.col != '0) &&
                          (({1'b0, emit_pos.col} + 1'b1) < w_eff);
  end

  // Advance raster counters and the pending count on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pos   <= '0;
      emit_pos <= '0;
      pending  <= '0;
    end else if (acc) begin
      if (is_drain) begin
        if (drn_emit) begin
          pending <= pending - 1'b1;
        end
      end else begin
        in_pos  <= next_pos(in_pos, w_eff, h_eff);
        pending <= pix_emit ? pend_inc - 1'b1 : pend_inc;
      end
      if (emit) begin
        emit_pos <= next_pos(emit_pos, w_eff, h_eff);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line read data, forwarding, line write, window shift
  // --------------------------------------------------------------------------
  logic     s1_pixel;
  logic     s1_emit;
  logic     s1_sel_older;
  pix_t     s1_pix;
  col_idx_t s1_addr;
  meta_t    s1_meta;
  logic     s1_fwd;
  pix_t     s1_fwd_older;
  pix_t     s1_fwd_newer;
  pix_t     ls_older;
  pix_t     ls_newer;
  pix_t     older_eff;
  pix_t     newer_eff;
  logic     s1_write;
  column_t  new_col;

  assign s1_write  = s1_valid && s1_pixel;
  assign older_eff = s1_fwd ? s1_fwd_older : ls_older;
  assign newer_eff = s1_fwd ? s1_fwd_newer : ls_newer;

  always_comb begin
    new_col.older = older_eff;
    new_col.newer = newer_eff;
    new_col.pix   = s1_pix;
    new_col.sum   = CSUM_BITS'(older_eff) + CSUM_BITS'(newer_eff) + CSUM_BITS'(s1_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  // Capture the beat; forward the line write still in flight to the same column
  always_ff @(posedge clk) begin
    s1_pixel     <= !is_drain;
    s1_emit      <= emit;
    s1_sel_older <= sel_older;
    s1_pix       <= pixels.pixel_in;
    s1_addr      <= rd_addr;
    s1_meta      <= emit_meta;
    s1_fwd       <= s1_write && (s1_addr == rd_addr);
    s1_fwd_older <= newer_eff;
    s1_fwd_newer <= s1_pix;
  end

  bf3_line_store u_lines (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_older (ls_older),
    .rd_newer (ls_newer),
    .wr_en    (s1_write),
    .wr_addr  (s1_addr),
    .wr_older (newer_eff),
    .wr_newer (s1_pix),
    .busy     (ls_busy)
  );

  // Window: cell chain, new column enters at the right end
  column_t win [WIN_COLS];
  column_t link_in [WIN_COLS];

  always_comb begin
    for (int i = 0; i < WIN_COLS - 1; i++) begin
      link_in[i] = win[i+1];
    end
    link_in[WIN_COLS-1] = new_col;
  end

  for (genvar gi = 0; gi < WIN_COLS; gi++) begin : g_cell
    bf3_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_write),
      .col_in (link_in[gi]),
      .col_q  (win[gi])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: window sum and center pick
  // --------------------------------------------------------------------------
  logic  s2_drain;
  pix_t  s2_value;
  meta_t s2_meta;
  pix_t  center;
  logic [TOTAL_BITS-1:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_drain <= !s1_pixel;
    s2_value <= s1_sel_older ? older_eff : newer_eff;
    s2_meta  <= s1_meta;
  end

  always_comb begin
    center = s2_drain ? s2_value : win[1].newer;
    total  = ROUND_BIAS;
    for (int i = 0; i < WIN_COLS; i++) begin
      total = total + TOTAL_BITS'(win[i].sum);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by nine through the reciprocal, then queue the result
  // --------------------------------------------------------------------------
  logic [TOTAL_BITS-1:0] s3_total;
  pix_t                  s3_center;
  logic                  s3_interior;
  meta_t                 s3_meta;
  logic [PROD_BITS-1:0]  prod;
  result_t               res_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_total    <= total;
    s3_center   <= center;
    s3_interior <= s2_meta.interior && !s2_drain;
    s3_meta     <= s2_meta;
  end

  always_comb begin
    prod = PROD_BITS'(s3_total) * PROD_BITS'(RECIP_9);
    res_push.pixel_out = s3_interior ? prod[RECIP_SHIFT +: PIX_BITS] : s3_center;
    res_push.out_row   = s3_meta.row;
    res_push.out_col   = s3_meta.col;
    res_push.frame_end = s3_meta.frame_end;
  end

  // --------------------------------------------------------------------------
  // Output queue: input is throttled so it never overflows
  // --------------------------------------------------------------------------
  result_t          oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_head;
  logic [OQ_AW-1:0] oq_tail;
  logic             oq_pop;

  assign results.valid = (oq_count != '0);
  assign oq_pop        = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head  <= '0;
      oq_tail  <= '0;
      oq_count <= '0;
    end else begin
      if (s3_valid) begin
        oq_tail <= oq_tail + 1'b1;
      end
      if (oq_pop) begin
        oq_head <= oq_head + 1'b1;
      end
      oq_count <= oq_count + (OQ_AW+1)'(s3_valid) - (OQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      oq_mem[oq_tail] <= res_push;
    end
  end

  // Present the head beat
  assign results.pixel_out = oq_mem[oq_head].pixel_out;
  assign results.out_row   = oq_mem[oq_head].out_row;
  assign results.out_col   = oq_mem[oq_head].out_col;
  assign results.frame_end = oq_mem[oq_head].frame_end;

endmodule
